/* rtl/ebfb_pkg.sv */
package ebfb_pkg;

	typedef enum logic [2:0] {
		K_FO   = 3'd0,
		K_BQ   = 3'd1,
		K_OFF  = 3'd2,
		K_GAIN = 3'd3,
		K_DAC  = 3'd4
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [1:0]  band;
		logic [2:0]  sec;
	} step_t;

	localparam int NSTEPS     = 23;
	localparam int HIST_DEPTH = 44;
	localparam int HIST_AW    = 6;
	localparam int BQ_HBASE   = 12;
	localparam int BQ_CBASE   = 18;
	localparam int HFRAC      = 14;
	localparam int ROM_FRAC   = 30;
	localparam logic [11:0] DAC_TOP = 12'd4095;

	localparam logic [2:0] REG_ALPHA_OFF  = 3'd0;
	localparam logic [2:0] REG_BETA_OFF   = 3'd1;
	localparam logic [2:0] REG_GAMMA_OFF  = 3'd2;
	localparam logic [2:0] REG_ALPHA_GAIN = 3'd3;
	localparam logic [2:0] REG_BETA_GAIN  = 3'd4;
	localparam logic [2:0] REG_GAMMA_GAIN = 3'd5;

	localparam logic [1:0] BAND_ALPHA = 2'd0;
	localparam logic [1:0] BAND_BETA  = 2'd1;
	localparam logic [1:0] BAND_GAMMA = 2'd2;

	// sequencer program, one entry per section or post operation
	localparam step_t PROG [NSTEPS] = '{
		'{K_FO,   BAND_ALPHA, 3'd0}, '{K_FO,   BAND_ALPHA, 3'd1}, '{K_FO,   BAND_ALPHA, 3'd2},
		'{K_OFF,  BAND_ALPHA, 3'd0}, '{K_FO,   BAND_ALPHA, 3'd3}, '{K_FO,   BAND_ALPHA, 3'd4},
		'{K_FO,   BAND_ALPHA, 3'd5}, '{K_GAIN, BAND_ALPHA, 3'd0}, '{K_DAC,  BAND_ALPHA, 3'd0},
		'{K_BQ,   BAND_BETA,  3'd0}, '{K_BQ,   BAND_BETA,  3'd1}, '{K_OFF,  BAND_BETA,  3'd0},
		'{K_GAIN, BAND_BETA,  3'd0}, '{K_BQ,   BAND_BETA,  3'd2}, '{K_BQ,   BAND_BETA,  3'd3},
		'{K_DAC,  BAND_BETA,  3'd0},
		'{K_BQ,   BAND_GAMMA, 3'd4}, '{K_BQ,   BAND_GAMMA, 3'd5}, '{K_OFF,  BAND_GAMMA, 3'd0},
		'{K_BQ,   BAND_GAMMA, 3'd6}, '{K_BQ,   BAND_GAMMA, 3'd7}, '{K_GAIN, BAND_GAMMA, 3'd0},
		'{K_DAC,  BAND_GAMMA, 3'd0}
	};

	// first-order: b0 b1 a1; biquads: b0 b1 b2 a1 a2; Q2.30
	localparam logic signed [63:0] COEF_ROM [58] = '{
		64'sd1072990205, -64'sd1072990205, -64'sd1072238585,
		64'sd1072990205, -64'sd1072990205, -64'sd1072238585,
		64'sd1072990205, -64'sd1072990205, -64'sd1072238585,
		64'sd4080219, 64'sd4080219, -64'sd1065688760,
		64'sd7301444, 64'sd7301444, -64'sd1059138935,
		64'sd5476083, 64'sd5476083, -64'sd1062789657,
		64'sd1011679547, -64'sd2023359093, 64'sd1011679547, -64'sd2143296055, 64'sd1069554231,
		64'sd990097336, -64'sd1980194672, 64'sd990097336, -64'sd2146409906, 64'sd1072668082,
		64'sd601402796, -64'sd1202590843, 64'sd601402796, -64'sd2138571591, 64'sd1065044515,
		64'sd337584429, -64'sd674954111, 64'sd337584429, -64'sd2134491372, 64'sd1060964296,
		64'sd1008673069, -64'sd2017346139, 64'sd1008673069, -64'sd2136853604, 64'sd1063219154,
		64'sd983869633, -64'sd1967739267, 64'sd983869633, -64'sd2132773385, 64'sd1059246309,
		64'sd471372661, -64'sd940812586, 64'sd471372661, -64'sd2107325704, 64'sd1035623989,
		64'sd981936898, -64'sd1961726312, 64'sd981936898, -64'sd2126438308, 64'sd1054843768
	};

endpackage

/* rtl/ebfb_hist_mem.sv */
module ebfb_hist_mem #(
	parameter int W = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ebfb_pkg::HIST_AW-1:0]  raddr,
	output logic [W-1:0]                  rdata,
	input  logic                          we,
	input  logic [ebfb_pkg::HIST_AW-1:0]  waddr,
	input  logic [W-1:0]                  wdata
);

	logic [W-1:0] mem [ebfb_pkg::HIST_DEPTH];
	logic [ebfb_pkg::HIST_DEPTH-1:0] valid_q;
	logic [W-1:0] rd_s1;
	logic         rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_s1 <= valid_q[raddr];
		end
	end

	assign rdata = rvld_s1 ? rd_s1 : '0;

endmodule

/* rtl/eeg_band_filter_bank_top.sv */
// channel | dir | handshake              | payload
// s_axis  | in  | s_tvalid / s_tready    | s_tdata[11:0] adc_sample
// m_axis  | out | m_tvalid / m_tready    | m_tdata alpha/beta/gamma, m_tuser clip_flags
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// One sample is worked through to the end before the next is accepted: one shared MAC walks
// 58 terms over 14 sections, each term as a history RAM read, a multiply and an
// accumulate, plus section writeback and offset, gain and clamp steps.
// Reset clears the history (valid bits) and loads register defaults.
// A finished word waits in the output register; a new sample is taken once
// the sequencer is idle, and the final load stalls only while m_tready is low.
module eeg_band_filter_bank_top #(
	parameter int COEF_FRAC_BITS = 30,
	parameter int HIST_WIDTH     = 32,
	parameter int SAMPLE_BITS    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] adc_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [11:0] alpha_level, [23:12] beta_level, [35:24] gamma_level
	output logic [2:0]  m_tuser,   // [2:0] clip_flags
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int HW    = HIST_WIDTH;
	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int PW    = HW + CW;
	localparam int ACC_W = HW + 4;
	localparam int EW    = HW + 20;
	localparam int GW    = HW + 17;
	localparam int RS    = ebfb_pkg::ROM_FRAC - COEF_FRAC_BITS;
	localparam logic signed [63:0] HALF = (RS == 0) ? 64'sd0 : (64'sd1 <<< (RS - 1));
	localparam logic signed [EW-1:0] HI_EXT = EW'((64'sd1 <<< (HW - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] LO_EXT = -HI_EXT - EW'(1);
	localparam logic signed [EW-1:0] TOP_EXT = EW'(64'sd1 <<< 26);
	localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_STEP  = 9'b000000010,
		S_RD    = 9'b000000100,
		S_MUL   = 9'b000001000,
		S_ACC   = 9'b000010000,
		S_FIN   = 9'b000100000,
		S_WB    = 9'b001000000,
		S_GAIN2 = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	function automatic logic signed [HW-1:0] sat_h(input logic signed [EW-1:0] a);
		if (a > HI_EXT) return HI_EXT[HW-1:0];
		if (a < LO_EXT) return LO_EXT[HW-1:0];
		return a[HW-1:0];
	endfunction

	state_t state_q;
	logic [4:0] pc_q;
	logic [2:0] j_q;
	logic [1:0] w_q;
	logic signed [HW-1:0] x_q, v_q, xs_q, st0_q, st2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [GW-1:0] gprod_q;
	logic [11:0] off_q [3];
	logic [15:0] gain_q [3];
	logic [11:0] lvl_q [3];
	logic [2:0]  clip_q;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	ebfb_pkg::step_t step;
	logic is_bq, last_term, sub_term;
	logic [2:0] nterms;
	logic [5:0] hbase, cbase, cidx;
	logic [ebfb_pkg::HIST_AW-1:0] raddr, waddr;
	logic [HW-1:0] rdata, wdata;
	logic we;
	logic signed [63:0] coef_full;
	logic signed [CW-1:0] coef_c;
	logic signed [HW-1:0] operand;
	logic signed [PW-1:0] prod_sh;
	logic signed [ACC_W-1:0] term;
	logic [15:0] smp16;
	logic signed [HW-1:0] x_in;
	logic signed [EW-1:0] v_ext, off_sum, acc_ext, g_ext;
	logic dac_neg, dac_big;
	logic [11:0] dac_lvl;
	logic s_acc;

	assign step      = ebfb_pkg::PROG[pc_q];
	assign is_bq     = (step.kind == ebfb_pkg::K_BQ);
	assign nterms    = is_bq ? 3'd5 : 3'd3;
	assign last_term = (j_q == nterms - 3'd1);
	assign sub_term  = is_bq ? (j_q >= 3'd3) : (j_q == 3'd2);
	assign hbase     = is_bq ? 6'(ebfb_pkg::BQ_HBASE + 4 * step.sec) : 6'(2 * step.sec);
	assign cbase     = is_bq ? 6'(ebfb_pkg::BQ_CBASE + 5 * step.sec) : 6'(3 * step.sec);
	assign cidx      = cbase + 6'(j_q);
	assign raddr     = (j_q == 3'd0) ? hbase : hbase + 6'(j_q) - 6'd1;

	// coefficient rounded to nearest at the configured fraction width
	assign coef_full = (ebfb_pkg::COEF_ROM[cidx] + HALF) >>> RS;
	assign coef_c    = coef_full[CW-1:0];
	assign operand   = (j_q == 3'd0) ? xs_q : $signed(rdata);
	assign prod_sh   = prod_q >>> COEF_FRAC_BITS;
	assign term      = prod_sh[ACC_W-1:0];

	assign smp16   = {4'b0, s_tdata[11:0]} & SMASK;
	assign x_in    = sat_h($signed({{(EW - 30){1'b0}}, smp16, 14'b0}));
	assign v_ext   = {{(EW - HW){v_q[HW-1]}}, v_q};
	assign off_sum = v_ext + $signed({{(EW - 26){1'b0}}, off_q[step.band], 14'b0});
	assign acc_ext = {{(EW - ACC_W){acc_q[ACC_W-1]}}, acc_q};
	assign g_ext   = {{(EW - GW){gprod_q[GW-1]}}, gprod_q >>> 12};
	assign dac_neg = v_q[HW-1];
	assign dac_big = v_ext >= TOP_EXT;
	assign dac_lvl = dac_neg ? 12'd0 : (dac_big ? ebfb_pkg::DAC_TOP : v_ext[25:14]);

	// writeback order keeps the delay-line shift: FO x,y; BQ x1->x2, x, y1->y2, y
	always_comb begin
		we    = (state_q == S_WB);
		waddr = hbase;
		wdata = xs_q;
		if (is_bq) begin
			case (w_q)
				2'd0: begin waddr = hbase + 6'd1; wdata = st0_q; end
				2'd1: begin waddr = hbase;        wdata = xs_q;  end
				2'd2: begin waddr = hbase + 6'd3; wdata = st2_q; end
				default: begin waddr = hbase + 6'd2; wdata = v_q; end
			endcase
		end else if (w_q[0]) begin
			waddr = hbase + 6'd1;
			wdata = v_q;
		end
	end

	ebfb_hist_mem #(.W(HW)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (rdata),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			j_q        <= '0;
			w_q        <= '0;
			m_tvalid_q <= 1'b0;
			off_q[0]   <= 12'd1500;
			off_q[1]   <= 12'd1500;
			off_q[2]   <= 12'd1700;
			gain_q[0]  <= 16'd6144;
			gain_q[1]  <= 16'd4506;
			gain_q[2]  <= 16'd6144;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ebfb_pkg::REG_ALPHA_OFF:  off_q[0]  <= cfg_data[11:0];
					ebfb_pkg::REG_BETA_OFF:   off_q[1]  <= cfg_data[11:0];
					ebfb_pkg::REG_GAMMA_OFF:  off_q[2]  <= cfg_data[11:0];
					ebfb_pkg::REG_ALPHA_GAIN: gain_q[0] <= cfg_data;
					ebfb_pkg::REG_BETA_GAIN:  gain_q[1] <= cfg_data;
					ebfb_pkg::REG_GAMMA_GAIN: gain_q[2] <= cfg_data;
					default: ;
				endcase
			end
			// S_DONE reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						pc_q    <= '0;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					j_q <= '0;
					w_q <= '0;
					unique case (step.kind) inside
						ebfb_pkg::K_FO, ebfb_pkg::K_BQ: state_q <= S_RD;
						ebfb_pkg::K_GAIN: state_q <= S_GAIN2;
						default: begin
							if (pc_q == 5'(ebfb_pkg::NSTEPS - 1)) begin
								state_q <= S_DONE;
							end else begin
								pc_q <= pc_q + 5'd1;
							end
						end
					endcase
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (last_term) begin
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + 3'd1;
						state_q <= S_RD;
					end
				end
				S_FIN: state_q <= S_WB;
				S_WB: begin
					w_q <= w_q + 2'd1;
					if (w_q == (is_bq ? 2'd3 : 2'd1)) begin
						pc_q    <= pc_q + 5'd1;
						state_q <= S_STEP;
					end
				end
				S_GAIN2: begin
					pc_q    <= pc_q + 5'd1;
					state_q <= S_STEP;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					x_q <= x_in;
					v_q <= x_in;
				end
			end
			S_STEP: begin
				xs_q <= v_q;
				case (step.kind)
					ebfb_pkg::K_OFF:  v_q <= sat_h(off_sum);
					ebfb_pkg::K_GAIN: gprod_q <= v_q * $signed({1'b0, gain_q[step.band]});
					ebfb_pkg::K_DAC: begin
						lvl_q[step.band]  <= dac_lvl;
						clip_q[step.band] <= dac_neg || dac_big;
						v_q               <= x_q;
					end
					default: ;
				endcase
			end
			S_MUL: begin
				prod_q <= operand * coef_c;
				if (j_q == 3'd1) st0_q <= operand;
				if (j_q == 3'd3) st2_q <= operand;
			end
			S_ACC: begin
				if (j_q == 3'd0) acc_q <= term;
				else if (sub_term) acc_q <= acc_q - term;
				else acc_q <= acc_q + term;
			end
			S_FIN:   v_q <= sat_h(acc_ext);
			S_GAIN2: v_q <= sat_h(g_ext);
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {4'b0, lvl_q[2], lvl_q[1], lvl_q[0]};
					m_tuser_q <= clip_q;
				end
			end
			default: ;
		endcase
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q == S_STEP) && (pc_q == 5'd0))
		else $error("sequencer did not start at first step");

	a_no_wb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !we)
		else $error("history write outside a section");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (j_q < nterms))
		else $error("term index past section end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && m_tvalid_q && !m_tready) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule
